FILE: hdl/vct_pkg.sv
// shared constants, payload types and the arctangent table of the view cone test
package vct_pkg;

   localparam int POS_BITS      = 24;
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int RANGE_BITS    = 24;
   localparam int DIR_BITS      = 16;
   localparam int HALF_BITS     = 16;
   localparam int HEAD_BITS     = 16;

   localparam int GUARD_BITS = 61 - POS_BITS;
   localparam int CW         = 64;
   localparam int ACC_W      = 32;
   localparam int ITER       = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
   localparam int PREP_DEPTH = 3;
   localparam int PIPE_DEPTH = PREP_DEPTH + ITER + 1;

   localparam int DIFF_W = POS_BITS + 1;
   localparam int MAG_W  = POS_BITS;
   localparam int CMP_W  = (POS_BITS > RANGE_BITS) ? POS_BITS : RANGE_BITS;
   localparam int SQ_W   = 2 * CMP_W + 1;
   localparam int LIM_W  = (ANGLE_BITS + 1 > HALF_BITS) ? ANGLE_BITS + 1 : HALF_BITS;

   localparam logic [ACC_W-1:0] QUARTER_TURN       = ACC_W'(1) << (ACC_W - 2);
   localparam logic [ACC_W-1:0] THREE_QUARTER_TURN = ACC_W'(3) << (ACC_W - 2);
   localparam logic [ACC_W-1:0] ROUND_HALF         = ACC_W'(1) << (ACC_W - 1 - ANGLE_BITS);
   localparam logic [LIM_W-1:0] AGENT_LIMIT        = LIM_W'(3) << (ANGLE_BITS - 3);
   localparam logic [LIM_W-1:0] ANGLE_WRAP         = LIM_W'(1) << ANGLE_BITS;

   localparam logic KIND_PLAYER = 1'b0;
   localparam logic KIND_AGENT  = 1'b1;

   typedef struct packed {
      logic                        kind;
      logic signed [POS_BITS-1:0]  observer_x;
      logic signed [POS_BITS-1:0]  observer_z;
      logic [RANGE_BITS-1:0]       view_range;
      logic [HALF_BITS-1:0]        half_angle;
      logic signed [HEAD_BITS-1:0] heading;
      logic signed [POS_BITS-1:0]  target_x;
      logic signed [POS_BITS-1:0]  target_z;
      logic signed [DIR_BITS-1:0]  target_dir_x;
      logic signed [DIR_BITS-1:0]  target_dir_z;
      logic                        is_self;
      logic                        last_in;
   } req_type;

   // fields that ride along the pipeline untouched until the decision
   typedef struct packed {
      logic                        kind;
      logic [HALF_BITS-1:0]        half_angle;
      logic signed [HEAD_BITS-1:0] heading;
      logic signed [POS_BITS-1:0]  target_x;
      logic signed [POS_BITS-1:0]  target_z;
      logic signed [DIR_BITS-1:0]  target_dir_x;
      logic signed [DIR_BITS-1:0]  target_dir_z;
      logic                        last_in;
   } side_type;

   typedef struct packed {
      logic signed [CW-1:0] u;
      logic signed [CW-1:0] v;
      logic [ACC_W-1:0]     acc;
      logic                 gate;
      side_type             side;
   } cordic_type;

   typedef struct packed {
      logic                       visible;
      logic                       kind_out;
      logic signed [POS_BITS-1:0] seen_x;
      logic signed [POS_BITS-1:0] seen_z;
      logic signed [DIR_BITS-1:0] seen_dir_x;
      logic signed [DIR_BITS-1:0] seen_dir_z;
      logic                       last_out;
   } rsp_type;

   // atan(2^-i) with a full turn at 2^32, truncated
   function automatic logic [ACC_W-1:0] atan_turn(input int idx);
      case (idx)
         0:       return 32'd536870912;
         1:       return 32'd316933405;
         2:       return 32'd167458907;
         3:       return 32'd85004756;
         4:       return 32'd42667331;
         5:       return 32'd21354465;
         6:       return 32'd10679838;
         7:       return 32'd5340245;
         8:       return 32'd2670163;
         9:       return 32'd1335086;
         10:      return 32'd667544;
         11:      return 32'd333772;
         12:      return 32'd166886;
         13:      return 32'd83443;
         14:      return 32'd41721;
         15:      return 32'd20860;
         16:      return 32'd10430;
         17:      return 32'd5215;
         18:      return 32'd2607;
         19:      return 32'd1303;
         20:      return 32'd651;
         21:      return 32'd325;
         22:      return 32'd162;
         23:      return 32'd81;
         default: return '0;
      endcase
   endfunction

endpackage

FILE: hdl/vct_if.sv
// request and response channel interfaces of the view cone test
interface vct_req_if;
   import vct_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic signed [POS_BITS-1:0]  observer_x;
   logic signed [POS_BITS-1:0]  observer_z;
   logic [RANGE_BITS-1:0]       view_range;
   logic [HALF_BITS-1:0]        half_angle;
   logic signed [HEAD_BITS-1:0] heading;
   logic signed [POS_BITS-1:0]  target_x;
   logic signed [POS_BITS-1:0]  target_z;
   logic signed [DIR_BITS-1:0]  target_dir_x;
   logic signed [DIR_BITS-1:0]  target_dir_z;
   logic                        is_self;
   logic                        last_in;

   modport source (
      output valid, kind, observer_x, observer_z, view_range, half_angle, heading,
             target_x, target_z, target_dir_x, target_dir_z, is_self, last_in,
      input  ready
   );

   modport sink (
      input  valid, kind, observer_x, observer_z, view_range, half_angle, heading,
             target_x, target_z, target_dir_x, target_dir_z, is_self, last_in,
      output ready
   );
endinterface

interface vct_rsp_if;
   import vct_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       visible;
   logic                       kind_out;
   logic signed [POS_BITS-1:0] seen_x;
   logic signed [POS_BITS-1:0] seen_z;
   logic signed [DIR_BITS-1:0] seen_dir_x;
   logic signed [DIR_BITS-1:0] seen_dir_z;
   logic                       last_out;

   modport source (
      output valid, visible, kind_out, seen_x, seen_z, seen_dir_x, seen_dir_z, last_out,
      input  ready
   );

   modport sink (
      input  valid, visible, kind_out, seen_x, seen_z, seen_dir_x, seen_dir_z, last_out,
      output ready
   );
endinterface

FILE: hdl/view_cone_visibility_test.sv
// top level of the view cone visibility test
// Accepts one candidate beat per clock while the pipeline is not stalled and returns one
// result beat per candidate, in order. The pipeline has three front stages for offsets,
// squared-distance range check and prerotation, one stage per CORDIC micro-rotation, and
// one stage for the heading compare that is also the output register. Every stage has its
// own valid bit and ready term, so a stalled response channel holds the pipeline in place
// while bubbles ahead of the stall keep filling; with the response side always ready the
// sustained rate is one beat per clock. Position and orientation of the candidate are
// echoed whether or not it is visible; the observer itself and a zero offset are never seen.
module view_cone_visibility_test (
   input  logic      clock,
   input  logic      reset,
   vct_req_if.sink   req_bus,
   vct_rsp_if.source rsp_bus
);
   import vct_pkg::*;

   req_type    req_item;
   rsp_type    rsp_item;
   cordic_type prep_data, cordic_data;
   logic       prep_valid, prep_ready;
   logic       cordic_valid, cordic_ready;

   always_comb begin
      req_item.kind         = req_bus.kind;
      req_item.observer_x   = req_bus.observer_x;
      req_item.observer_z   = req_bus.observer_z;
      req_item.view_range   = req_bus.view_range;
      req_item.half_angle   = req_bus.half_angle;
      req_item.heading      = req_bus.heading;
      req_item.target_x     = req_bus.target_x;
      req_item.target_z     = req_bus.target_z;
      req_item.target_dir_x = req_bus.target_dir_x;
      req_item.target_dir_z = req_bus.target_dir_z;
      req_item.is_self      = req_bus.is_self;
      req_item.last_in      = req_bus.last_in;
   end

   vct_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_item   (req_item),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   vct_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (cordic_valid),
      .out_ready (cordic_ready),
      .out_data  (cordic_data)
   );

   vct_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cordic_valid),
      .in_ready  (cordic_ready),
      .in_data   (cordic_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_item  (rsp_item)
   );

   assign rsp_bus.visible    = rsp_item.visible;
   assign rsp_bus.kind_out   = rsp_item.kind_out;
   assign rsp_bus.seen_x     = rsp_item.seen_x;
   assign rsp_bus.seen_z     = rsp_item.seen_z;
   assign rsp_bus.seen_dir_x = rsp_item.seen_dir_x;
   assign rsp_bus.seen_dir_z = rsp_item.seen_dir_z;
   assign rsp_bus.last_out   = rsp_item.last_out;

endmodule

FILE: hdl/vct_prep.sv
// front stages: offsets, range check by squared distance, quarter-turn prerotation
module vct_prep (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  vct_pkg::req_type    in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output vct_pkg::cordic_type out_data
);
   import vct_pkg::*;

   // stage 1: offsets
   logic                     s1_valid_ff;
   logic signed [DIFF_W-1:0] dx_ff, dz_ff;
   logic signed [DIFF_W-1:0] dx_in, dz_in;
   logic [RANGE_BITS-1:0]    range1_ff;
   logic                     self1_ff;
   side_type                 side1_ff, side_in;
   logic                     s1_ready;

   // stage 2: squares, per-axis compares, prerotation
   logic                     s2_valid_ff;
   logic [2*MAG_W-1:0]       sqx_ff, sqz_ff, sqx_in, sqz_in;
   logic [2*RANGE_BITS-1:0]  rsq_ff, rsq_in;
   logic                     lex_ff, lez_ff, nz_ff, self2_ff;
   logic                     lex_in, lez_in, nz_in;
   logic signed [CW-1:0]     u2_ff, v2_ff, u2_in, v2_in;
   logic [ACC_W-1:0]         acc2_ff, acc2_in;
   side_type                 side2_ff;
   logic                     s2_ready;
   logic [MAG_W-1:0]         ax, az;
   logic signed [CW-1:0]     u_raw, v_raw;

   // stage 3: range decision
   logic                     s3_valid_ff;
   cordic_type               s3_ff, s3_in;
   logic                     s3_ready;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      dx_in                = DIFF_W'(in_item.target_x) - DIFF_W'(in_item.observer_x);
      dz_in                = DIFF_W'(in_item.target_z) - DIFF_W'(in_item.observer_z);
      side_in.kind         = in_item.kind;
      side_in.half_angle   = in_item.half_angle;
      side_in.heading      = in_item.heading;
      side_in.target_x     = in_item.target_x;
      side_in.target_z     = in_item.target_z;
      side_in.target_dir_x = in_item.target_dir_x;
      side_in.target_dir_z = in_item.target_dir_z;
      side_in.last_in      = in_item.last_in;
   end

   always_comb begin
      ax     = dx_ff[DIFF_W-1] ? MAG_W'(-dx_ff) : MAG_W'(dx_ff);
      az     = dz_ff[DIFF_W-1] ? MAG_W'(-dz_ff) : MAG_W'(dz_ff);
      sqx_in = (2*MAG_W)'(ax) * (2*MAG_W)'(ax);
      sqz_in = (2*MAG_W)'(az) * (2*MAG_W)'(az);
      rsq_in = (2*RANGE_BITS)'(range1_ff) * (2*RANGE_BITS)'(range1_ff);
      lex_in = CMP_W'(ax) <= CMP_W'(range1_ff);
      lez_in = CMP_W'(az) <= CMP_W'(range1_ff);
      nz_in  = (dx_ff != '0) || (dz_ff != '0);
      u_raw  = CW'(dz_ff) <<< GUARD_BITS;
      v_raw  = CW'(dx_ff) <<< GUARD_BITS;
      // vectors behind the observer get a quarter turn so the iterations converge
      if (u_raw[CW-1]) begin
         if (!v_raw[CW-1]) begin
            u2_in   = v_raw;
            v2_in   = -u_raw;
            acc2_in = QUARTER_TURN;
         end else begin
            u2_in   = -v_raw;
            v2_in   = u_raw;
            acc2_in = THREE_QUARTER_TURN;
         end
      end else begin
         u2_in   = u_raw;
         v2_in   = v_raw;
         acc2_in = '0;
      end
   end

   always_comb begin
      s3_in.u    = u2_ff;
      s3_in.v    = v2_ff;
      s3_in.acc  = acc2_ff;
      s3_in.side = side2_ff;
      s3_in.gate = !self2_ff && nz_ff && lex_ff && lez_ff &&
                   (SQ_W'(sqx_ff) + SQ_W'(sqz_ff) <= SQ_W'(rsq_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         dx_ff     <= dx_in;
         dz_ff     <= dz_in;
         range1_ff <= in_item.view_range;
         self1_ff  <= in_item.is_self;
         side1_ff  <= side_in;
      end
      if (s2_ready && s1_valid_ff) begin
         sqx_ff   <= sqx_in;
         sqz_ff   <= sqz_in;
         rsq_ff   <= rsq_in;
         lex_ff   <= lex_in;
         lez_ff   <= lez_in;
         nz_ff    <= nz_in;
         self2_ff <= self1_ff;
         u2_ff    <= u2_in;
         v2_ff    <= v2_in;
         acc2_ff  <= acc2_in;
         side2_ff <= side1_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

endmodule

FILE: hdl/vct_cordic.sv
// vectoring cordic, one micro-rotation per register stage
module vct_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  vct_pkg::cordic_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output vct_pkg::cordic_type out_data
);
   import vct_pkg::*;

   logic       valid_ff [ITER];
   cordic_type stage_ff [ITER];
   logic       ready    [ITER];

   for (genvar k = 0; k < ITER; k++) begin : g_stage
      cordic_type           src, nxt;
      logic                 src_valid, dn_ready;
      logic signed [CW-1:0] u_cur, v_cur, su, sv;

      if (k == 0) begin : g_first
         assign src       = in_data;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src       = stage_ff[k-1];
         assign src_valid = valid_ff[k-1];
      end

      if (k == ITER - 1) begin : g_last
         assign dn_ready = out_ready;
      end else begin : g_mid
         assign dn_ready = ready[k+1];
      end

      assign ready[k] = !valid_ff[k] || dn_ready;

      always_comb begin
         u_cur = src.u;
         v_cur = src.v;
         su    = u_cur >>> k;
         sv    = v_cur >>> k;
         nxt   = src;
         // both updates use the values from the previous stage
         if (!v_cur[CW-1]) begin
            nxt.u   = u_cur + sv;
            nxt.v   = v_cur - su;
            nxt.acc = src.acc + atan_turn(k);
         end else begin
            nxt.u   = u_cur - sv;
            nxt.v   = v_cur + su;
            nxt.acc = src.acc - atan_turn(k);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ready[k]) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[k] && src_valid) begin
            stage_ff[k] <= nxt;
         end
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[ITER-1];
   assign out_data  = stage_ff[ITER-1];

endmodule

FILE: hdl/vct_decide.sv
// bearing rounding, wrapped difference to heading, cone compare and output register
module vct_decide (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  vct_pkg::cordic_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output vct_pkg::rsp_type    out_item
);
   import vct_pkg::*;

   logic                  out_valid_ff;
   rsp_type               rsp_ff, rsp_in;
   logic [ACC_W-1:0]      rounded;
   logic [ANGLE_BITS-1:0] bearing, head, diff;
   logic [LIM_W-1:0]      absd, limit;

   assign in_ready = !out_valid_ff || out_ready;

   always_comb begin
      rounded = in_data.acc + ROUND_HALF;
      bearing = rounded[ACC_W-1 -: ANGLE_BITS];
      head    = ANGLE_BITS'($unsigned(in_data.side.heading));
      diff    = bearing - head;
      // a difference of exactly a half turn keeps magnitude a half turn
      absd    = diff[ANGLE_BITS-1] ? (ANGLE_WRAP - LIM_W'(diff)) : LIM_W'(diff);
      limit   = (in_data.side.kind == KIND_AGENT) ? AGENT_LIMIT
                                                  : LIM_W'(in_data.side.half_angle);
      rsp_in.visible    = in_data.gate && (absd <= limit);
      rsp_in.kind_out   = in_data.side.kind;
      rsp_in.seen_x     = in_data.side.target_x;
      rsp_in.seen_z     = in_data.side.target_z;
      rsp_in.seen_dir_x = in_data.side.target_dir_x;
      rsp_in.seen_dir_z = in_data.side.target_dir_z;
      rsp_in.last_out   = in_data.side.last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_ready) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = rsp_ff;

endmodule

FILE: hdl/vct_checker.sv
// port-level checks of the view cone test and their binding to the top level
module vct_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_visible,
   input logic                                rsp_kind_out,
   input logic signed [vct_pkg::POS_BITS-1:0] rsp_seen_x,
   input logic signed [vct_pkg::POS_BITS-1:0] rsp_seen_z,
   input logic signed [vct_pkg::DIR_BITS-1:0] rsp_seen_dir_x,
   input logic signed [vct_pkg::DIR_BITS-1:0] rsp_seen_dir_z,
   input logic                                rsp_last_out
);
   import vct_pkg::*;

   localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // beats accepted but not yet delivered
   always_comb begin
      count_in = count_ff + CNT_W'(req_beat) - CNT_W'(rsp_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_visible, rsp_kind_out, rsp_seen_x, rsp_seen_z,
                                           rsp_seen_dir_x, rsp_seen_dir_z, rsp_last_out}))
      else $error("response payload changed while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != '0)
      else $error("response beat without a pending request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(PIPE_DEPTH))
      else $error("more beats in flight than pipeline stages");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("pipeline not empty after reset");

endmodule

bind view_cone_visibility_test vct_checker u_vct_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_visible    (rsp_bus.visible),
   .rsp_kind_out   (rsp_bus.kind_out),
   .rsp_seen_x     (rsp_bus.seen_x),
   .rsp_seen_z     (rsp_bus.seen_z),
   .rsp_seen_dir_x (rsp_bus.seen_dir_x),
   .rsp_seen_dir_z (rsp_bus.seen_dir_z),
   .rsp_last_out   (rsp_bus.last_out)
);
